// ----- hw/rtl/vector_pair_distance_angle_area_core_assert.svh -----
// assertion macros for the vector pair distance, angle and area core
// no dependencies; included by the top-level core, which checks its own logic
`ifndef VECTOR_PAIR_DISTANCE_ANGLE_AREA_CORE_ASSERT_SVH
`define VECTOR_PAIR_DISTANCE_ANGLE_AREA_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define VPDA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define VPDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define VPDA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define VPDA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hw/rtl/vpda_pkg.sv -----
// shared constants for the vector pair distance, angle and area core
// no dependencies
package vpda_pkg;

    localparam int DIST_W       = 26;
    localparam int ANGLE_W      = 24;
    localparam int AREA_W       = 38;
    localparam int CORDIC_STEPS = 23;
    localparam int SQ_ST        = 16;

    localparam logic [ANGLE_W-1:0] DEG45  = 24'd2949120;
    localparam logic [ANGLE_W-1:0] DEG90  = 24'd5898240;
    localparam logic [ANGLE_W-1:0] DEG180 = 24'd11796480;

    localparam logic [ANGLE_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        24'd2949120, 24'd1740967, 24'd919879, 24'd466945, 24'd234379, 24'd117304,
        24'd58666, 24'd29335, 24'd14668, 24'd7334, 24'd3667, 24'd1833, 24'd917,
        24'd458, 24'd229, 24'd115, 24'd57, 24'd29, 24'd14, 24'd7, 24'd4, 24'd2, 24'd1
    };

endpackage

// ----- hw/rtl/vpda_if.sv -----
// point pair and result channels with valid/ready handshake
// depends on vpda_pkg
interface vpda_in_if #(
    parameter int COORD_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;

    modport source (output valid, ax, ay, bx, by, input ready);
    modport sink (input valid, ax, ay, bx, by, output ready);
endinterface

interface vpda_out_if;
    import vpda_pkg::*;
    logic               valid;
    logic               ready;
    logic [DIST_W-1:0]  dist_a;
    logic [DIST_W-1:0]  dist_b;
    logic [DIST_W-1:0]  dist_ab;
    logic [ANGLE_W-1:0] angle_deg;
    logic               angle_valid;
    logic [AREA_W-1:0]  area;

    modport source (output valid, dist_a, dist_b, dist_ab, angle_deg, angle_valid, area,
                    input ready);
    modport sink (input valid, dist_a, dist_b, dist_ab, angle_deg, angle_valid, area,
                  output ready);
endinterface

// ----- hw/rtl/vpda_sqrt.sv -----
// pipelined integer square root, two result bits per stage
// depends on vpda_pkg; root and remainder come out of the last of SQ_ST registered stages
module vpda_sqrt #(
    parameter int RAD_W = 50
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [RAD_W-1:0]       i_rad,
    output logic [RAD_W/2-1:0]     o_root,
    output logic [RAD_W/2+1:0]     o_rem
);
    import vpda_pkg::*;

    localparam int RW   = RAD_W / 2;
    localparam int SQ_N = RAD_W / 2;

    logic [RAD_W-1:0] r_rad  [SQ_ST];
    logic [RW-1:0]    r_root [SQ_ST];
    logic [RW+1:0]    r_rem  [SQ_ST];

    for (genvar k = 0; k < SQ_ST; k++) begin : g_stg
        logic [RAD_W-1:0] w_rad;
        logic [RW-1:0]    w_root [3];
        logic [RW+1:0]    w_rem  [3];

        if (k == 0) begin : g_first
            assign w_rad     = i_rad;
            assign w_root[0] = '0;
            assign w_rem[0]  = '0;
        end else begin : g_next
            assign w_rad     = r_rad[k-1];
            assign w_root[0] = r_root[k-1];
            assign w_rem[0]  = r_rem[k-1];
        end

        for (genvar j = 0; j < 2; j++) begin : g_step
            localparam int S   = 2 * k + j;
            localparam int IDX = (S < SQ_N) ? 2 * (SQ_N - 1 - S) : 0;
            if (S < SQ_N) begin : g_act
                logic [RW+3:0] t_rem;
                logic [RW+3:0] trial;
                logic          take;
                assign t_rem = {w_rem[j], w_rad[IDX +: 2]};
                assign trial = (RW+4)'({w_root[j], 2'b01});
                assign take  = (t_rem >= trial);
                assign w_root[j+1] = {w_root[j][RW-2:0], take};
                assign w_rem[j+1]  = take ? (RW+2)'(t_rem - trial) : (RW+2)'(t_rem);
            end else begin : g_idle
                assign w_root[j+1] = w_root[j];
                assign w_rem[j+1]  = w_rem[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k]  <= w_rad;
                r_root[k] <= w_root[2];
                r_rem[k]  <= w_rem[2];
            end
        end
    end

    assign o_root = r_root[SQ_ST-1];
    assign o_rem  = r_rem[SQ_ST-1];

endmodule

// ----- hw/rtl/vector_pair_distance_angle_area_core.sv -----
// top level: distances, angle and triangle area of a point pair
// depends on vpda_pkg, vpda_if, vpda_sqrt and the assertion header
//
//  channel  | dir | handshake     | payload
//  i_pt     | in  | valid / ready | ax, ay, bx, by
//  o_res    | out | valid / ready | dist_a, dist_b, dist_ab, angle_deg, angle_valid, area
//
// one pair per cycle while the result channel is not stalled
// the 16 stage square root runs alongside normalize and 12 cordic stages
// a stalled result freezes the whole pipeline; no beat is lost or repeated
// reset clears the valid bits only; the block takes beats the cycle after reset
module vector_pair_distance_angle_area_core #(
    parameter int COORD_BITS = 24,
    parameter int FRAC_BITS  = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    vpda_in_if.sink        i_pt,
    vpda_out_if.source     o_res
);
    import vpda_pkg::*;

    `include "vector_pair_distance_angle_area_core_assert.svh"

    localparam int CW    = COORD_BITS;
    localparam int PW    = 2 * CW;
    localparam int DPW   = 2 * CW + 2;
    localparam int SW    = 2 * CW + 1;
    localparam int MW    = 2 * CW;
    localparam int RAD_W = (2 * CW + 2 > 64) ? 64 : 2 * CW + 2;
    localparam int RW    = RAD_W / 2;
    localparam int XW    = 43;
    localparam int ZW    = 26;
    localparam int NST   = 17;

    typedef struct packed {
        logic                 vld;
        logic                 ok;
        logic                 dneg;
        logic                 swp;
        logic [AREA_W-1:0]    area;
        logic [63:0]          d;
        logic [63:0]          c;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic [DIST_W-1:0]    da;
        logic [DIST_W-1:0]    db;
        logic [DIST_W-1:0]    dab;
    } t_st;

    logic en;

    logic                 r_s0_vld;
    logic signed [CW-1:0] r_s0_ax, r_s0_ay, r_s0_bx, r_s0_by;

    logic                  r_s1_vld, r_s1_ok;
    logic signed [PW-1:0]  r_s1_aa, r_s1_ayy, r_s1_bb, r_s1_byy;
    logic signed [DPW-1:0] r_s1_dxx, r_s1_dyy;
    logic signed [PW-1:0]  r_s1_axbx, r_s1_ayby, r_s1_axby, r_s1_bxay;

    logic                 r_s2_vld, r_s2_ok;
    logic [RAD_W-1:0]     r_s2_na, r_s2_nb, r_s2_nab;
    logic signed [SW-1:0] r_s2_dot, r_s2_crs;

    logic signed [CW:0]   dx, dy;
    logic [DPW-1:0]       sum_na, sum_nb, sum_nab;

    t_st r_st [NST];
    t_st n_st [NST];

    logic [RW-1:0] root_a, root_b, root_ab;
    logic [RW+1:0] rem_a, rem_b, rem_ab;

    assign en         = !r_st[NST-1].vld || o_res.ready;
    assign i_pt.ready = en;

    // front: capture, products, sums
    assign dx = (CW+1)'(r_s0_bx) - (CW+1)'(r_s0_ax);
    assign dy = (CW+1)'(r_s0_by) - (CW+1)'(r_s0_ay);

    assign sum_na  = DPW'($unsigned(r_s1_aa)) + DPW'($unsigned(r_s1_ayy));
    assign sum_nb  = DPW'($unsigned(r_s1_bb)) + DPW'($unsigned(r_s1_byy));
    assign sum_nab = $unsigned(r_s1_dxx) + $unsigned(r_s1_dyy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else if (en) begin
            r_s0_vld <= i_pt.valid;
            r_s1_vld <= r_s0_vld;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_ax   <= i_pt.ax;
            r_s0_ay   <= i_pt.ay;
            r_s0_bx   <= i_pt.bx;
            r_s0_by   <= i_pt.by;
            r_s1_ok   <= ((r_s0_ax != '0) || (r_s0_ay != '0))
                      && ((r_s0_bx != '0) || (r_s0_by != '0));
            r_s1_aa   <= PW'(r_s0_ax) * PW'(r_s0_ax);
            r_s1_ayy  <= PW'(r_s0_ay) * PW'(r_s0_ay);
            r_s1_bb   <= PW'(r_s0_bx) * PW'(r_s0_bx);
            r_s1_byy  <= PW'(r_s0_by) * PW'(r_s0_by);
            r_s1_dxx  <= DPW'(dx) * DPW'(dx);
            r_s1_dyy  <= DPW'(dy) * DPW'(dy);
            r_s1_axbx <= PW'(r_s0_ax) * PW'(r_s0_bx);
            r_s1_ayby <= PW'(r_s0_ay) * PW'(r_s0_by);
            r_s1_axby <= PW'(r_s0_ax) * PW'(r_s0_by);
            r_s1_bxay <= PW'(r_s0_bx) * PW'(r_s0_ay);
            r_s2_ok   <= r_s1_ok;
            r_s2_na   <= RAD_W'(sum_na);
            r_s2_nb   <= RAD_W'(sum_nb);
            r_s2_nab  <= RAD_W'(sum_nab);
            r_s2_dot  <= SW'(r_s1_axbx) + SW'(r_s1_ayby);
            r_s2_crs  <= SW'(r_s1_axby) - SW'(r_s1_bxay);
        end
    end

    vpda_sqrt #(.RAD_W(RAD_W)) u_sqrt_a (
        .i_clk (i_clk), .i_en (en), .i_rad (r_s2_na), .o_root (root_a), .o_rem (rem_a)
    );
    vpda_sqrt #(.RAD_W(RAD_W)) u_sqrt_b (
        .i_clk (i_clk), .i_en (en), .i_rad (r_s2_nb), .o_root (root_b), .o_rem (rem_b)
    );
    vpda_sqrt #(.RAD_W(RAD_W)) u_sqrt_ab (
        .i_clk (i_clk), .i_en (en), .i_rad (r_s2_nab), .o_root (root_ab), .o_rem (rem_ab)
    );

    // angle path: fold, normalize, cordic, unfold; the last stage rounds the distances
    always_comb begin
        t_st                  p;
        logic [MW-1:0]        dmag, cmag;
        logic [MW:0]          asum;
        logic [63:0]          d, c;
        logic signed [XW-1:0] x, y, nx, ny;
        logic signed [ZW-1:0] z, t;
        int                   i, sh;

        nx = '0;
        ny = '0;
        t  = '0;
        i  = 0;
        sh = 0;
        dmag = MW'(r_s2_dot < 0 ? -r_s2_dot : r_s2_dot);
        cmag = MW'(r_s2_crs < 0 ? -r_s2_crs : r_s2_crs);
        asum = {1'b0, cmag} + ((MW+1)'(1) << FRAC_BITS);
        p      = '0;
        p.vld  = r_s2_vld;
        p.ok   = r_s2_ok;
        p.dneg = (r_s2_dot < 0);
        p.swp  = (cmag > dmag);
        p.d    = p.swp ? 64'(cmag) : 64'(dmag);
        p.c    = p.swp ? 64'(dmag) : 64'(cmag);
        p.area = AREA_W'(asum >> (FRAC_BITS + 1));
        n_st[0] = p;

        for (int k = 1; k < NST; k++) begin
            p = r_st[k-1];
            d = p.d;
            c = p.c;
            x = p.x;
            y = p.y;
            z = p.z;
            if (k == 1 || k == 2) begin
                for (int j = 0; j < 3; j++) begin
                    sh = (k == 1) ? (32 >> j) : (4 >> j);
                    if ((d >> (64 - sh)) == 64'd0) begin
                        d = d << sh;
                        c = c << sh;
                    end
                end
                x = $signed({3'b000, d[63:24]});
                y = $signed({3'b000, c[63:24]});
                z = '0;
            end else if (k >= 3 && k <= 14) begin
                for (int j = 0; j < 2; j++) begin
                    i = 2 * (k - 3) + j;
                    if (i < CORDIC_STEPS) begin
                        if (y > 0) begin
                            nx = x + (y >>> i);
                            ny = y - (x >>> i);
                            z  = z + $signed({2'b00, ATAN_TAB[i]});
                            x  = nx;
                            y  = ny;
                        end else if (y < 0) begin
                            nx = x - (y >>> i);
                            ny = y + (x >>> i);
                            z  = z - $signed({2'b00, ATAN_TAB[i]});
                            x  = nx;
                            y  = ny;
                        end
                    end
                end
            end else if (k == 15) begin
                if (z < 0) begin
                    z = '0;
                end
                if (z > $signed({2'b00, DEG45})) begin
                    z = $signed({2'b00, DEG45});
                end
                t = p.swp ? $signed({2'b00, DEG90}) - z : z;
                z = p.dneg ? $signed({2'b00, DEG180}) - t : t;
                if (!p.ok) begin
                    z = '0;
                end
            end else begin
                p.da  = DIST_W'({1'b0, root_a} + (RW+1)'(rem_a > (RW+2)'(root_a)));
                p.db  = DIST_W'({1'b0, root_b} + (RW+1)'(rem_b > (RW+2)'(root_b)));
                p.dab = DIST_W'({1'b0, root_ab} + (RW+1)'(rem_ab > (RW+2)'(root_ab)));
            end
            p.d = d;
            p.c = c;
            p.x = x;
            p.y = y;
            p.z = z;
            n_st[k] = p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NST; k++) begin
                r_st[k].vld <= 1'b0;
            end
        end else if (en) begin
            r_st <= n_st;
        end
    end

    assign o_res.valid       = r_st[NST-1].vld;
    assign o_res.dist_a      = r_st[NST-1].da;
    assign o_res.dist_b      = r_st[NST-1].db;
    assign o_res.dist_ab     = r_st[NST-1].dab;
    assign o_res.angle_deg   = ANGLE_W'(r_st[NST-1].z);
    assign o_res.angle_valid = r_st[NST-1].ok;
    assign o_res.area        = r_st[NST-1].area;

    `VPDA_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, o_res.valid && !o_res.ready, o_res.valid)
    `VPDA_ASSERT_IMP(a_origin_angle, i_clk, i_rst_n, o_res.valid && !o_res.angle_valid, o_res.angle_deg == '0)
    `VPDA_ASSERT_IMP(a_angle_range, i_clk, i_rst_n, o_res.valid, o_res.angle_deg <= DEG180)
    `VPDA_ASSERT_NEXT(a_beat_enters, i_clk, i_rst_n, i_pt.valid && i_pt.ready, r_s0_vld)

endmodule

// ----- tb/sv/testbench.sv -----
// self-checking testbench for vector_pair_distance_angle_area_core
// drives directed and random point pairs with idle and stall gaps, checks every result beat
// depends on vpda_pkg, vpda_if and the core rtl
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import vpda_pkg::*;

    localparam int  COORD_W     = 24;
    localparam int  FRAC_W      = 8;
    localparam int  LATENCY     = 20;
    localparam int  RAND_PAIRS  = 600;
    localparam int  CYCLE_LIMIT = 400000;
    localparam logic signed [COORD_W-1:0] CMAX = 24'sh7fffff;
    localparam logic signed [COORD_W-1:0] CMIN = 24'sh800000;

    typedef struct packed {
        logic [DIST_W-1:0]  dist_a;
        logic [DIST_W-1:0]  dist_b;
        logic [DIST_W-1:0]  dist_ab;
        logic [ANGLE_W-1:0] angle_deg;
        logic               angle_valid;
        logic [AREA_W-1:0]  area;
    } geom_t;

    typedef struct {
        logic signed [COORD_W-1:0] ax, ay, bx, by;
        bit                        known;
        geom_t                     want;
    } pair_row_t;

    logic i_clk;
    logic i_rst_n;
    vpda_in_if #(.COORD_BITS(COORD_W)) pt_if();
    vpda_out_if res_if();

    vector_pair_distance_angle_area_core #(
        .COORD_BITS(COORD_W),
        .FRAC_BITS (FRAC_W)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pt   (pt_if),
        .o_res  (res_if)
    );

    geom_t     pending_geom[$];
    pair_row_t pair_table[$];
    int        fail_cnt = 0;
    int        cycle_cnt = 0;
    bit        no_gaps = 0;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic longint unsigned sqrt_nearest(longint unsigned n);
        longint unsigned root = 0;
        longint unsigned bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root + ((n > root) ? 64'd1 : 64'd0);
    endfunction

    function automatic longint atan_first_octant(longint unsigned d, longint unsigned c);
        longint x, y, z, nx, ny;
        z = 0;
        while (d >= (64'd1 << 40)) begin
            d = d >> 1;
            c = c >> 1;
        end
        while (d < (64'd1 << 39)) begin
            d = d << 1;
            c = c << 1;
        end
        x = longint'(d);
        y = longint'(c);
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (y != 0) begin
                if (y > 0) begin
                    nx = x + (y >>> i);
                    ny = y - (x >>> i);
                    z = z + longint'(ATAN_TAB[i]);
                end else begin
                    nx = x - (y >>> i);
                    ny = y + (x >>> i);
                    z = z - longint'(ATAN_TAB[i]);
                end
                x = nx;
                y = ny;
            end
        end
        if (z < 0) z = 0;
        if (z > longint'(DEG45)) z = longint'(DEG45);
        return z;
    endfunction

    function automatic geom_t pair_geometry(logic signed [COORD_W-1:0] ax, ay, bx, by);
        geom_t g;
        longint sax, say, sbx, sby, dx, dy, dotp, crs, t;
        longint unsigned na, nb, nab, dmag, cmag;
        bit swapped;
        sax = ax;
        say = ay;
        sbx = bx;
        sby = by;
        dx = sbx - sax;
        dy = sby - say;
        na = sax * sax + say * say;
        nb = sbx * sbx + sby * sby;
        nab = dx * dx + dy * dy;
        dotp = sax * sbx + say * sby;
        crs = sax * sby - sbx * say;
        dmag = (dotp < 0) ? -dotp : dotp;
        cmag = (crs < 0) ? -crs : crs;
        g.dist_a = DIST_W'(sqrt_nearest(na));
        g.dist_b = DIST_W'(sqrt_nearest(nb));
        g.dist_ab = DIST_W'(sqrt_nearest(nab));
        g.area = AREA_W'((cmag + (64'd1 << FRAC_W)) >> (FRAC_W + 1));
        g.angle_deg = '0;
        g.angle_valid = 1'b0;
        if (na != 0 && nb != 0) begin
            swapped = cmag > dmag;
            t = swapped ? atan_first_octant(cmag, dmag) : atan_first_octant(dmag, cmag);
            if (swapped) t = longint'(DEG90) - t;
            if (dotp < 0) t = longint'(DEG180) - t;
            g.angle_deg = ANGLE_W'(t);
            g.angle_valid = 1'b1;
        end
        return g;
    endfunction

    task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
        $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_cnt, field, got, want);
        fail_cnt++;
    endtask

    task automatic add_row(logic signed [COORD_W-1:0] ax, ay, bx, by,
                           bit known, geom_t want);
        pair_row_t r;
        r.ax = ax;
        r.ay = ay;
        r.bx = bx;
        r.by = by;
        r.known = known;
        r.want = want;
        pair_table.push_back(r);
    endtask

    function automatic logic signed [COORD_W-1:0] rand_coord(int mode);
        case (mode)
            0: return COORD_W'($urandom);
            1: return COORD_W'($signed(COORD_W'($urandom_range(0, 2047))) - 1024);
            2: return ($urandom_range(0, 1) != 0) ? CMAX : CMIN;
            3: return '0;
            default: return COORD_W'($signed(COORD_W'($urandom_range(0, 65535))) - 32768);
        endcase
    endfunction

    // one pair beat; valid stays high after acceptance until the next call decides
    task automatic send_pair(pair_row_t r);
        @(negedge i_clk);
        while (!no_gaps && $urandom_range(0, 99) < 34) begin
            pt_if.valid = 1'b0;
            @(negedge i_clk);
        end
        pt_if.ax = r.ax;
        pt_if.ay = r.ay;
        pt_if.bx = r.bx;
        pt_if.by = r.by;
        pt_if.valid = 1'b1;
        do @(posedge i_clk); while (!pt_if.ready);
        pending_geom.push_back(r.known ? r.want : pair_geometry(r.ax, r.ay, r.bx, r.by));
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        pt_if.valid = 1'b0;
        while (pending_geom.size() != 0) @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin
        res_if.ready <= no_gaps ? 1'b1 : ($urandom_range(0, 99) >= 34);
    end

    always @(posedge i_clk) begin
        geom_t got, want;
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("vector_pair_distance_angle_area_core verification failed");
            $finish;
        end
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.dist_a = res_if.dist_a;
            got.dist_b = res_if.dist_b;
            got.dist_ab = res_if.dist_ab;
            got.angle_deg = res_if.angle_deg;
            got.angle_valid = res_if.angle_valid;
            got.area = res_if.area;
            if (pending_geom.size() == 0) begin
                report_mismatch("unexpected beat", 1, 0);
            end else begin
                want = pending_geom.pop_front();
                if (got.dist_a !== want.dist_a) report_mismatch("dist_a", got.dist_a, want.dist_a);
                if (got.dist_b !== want.dist_b) report_mismatch("dist_b", got.dist_b, want.dist_b);
                if (got.dist_ab !== want.dist_ab)
                    report_mismatch("dist_ab", got.dist_ab, want.dist_ab);
                if (got.angle_deg !== want.angle_deg)
                    report_mismatch("angle_deg", got.angle_deg, want.angle_deg);
                if (got.angle_valid !== want.angle_valid)
                    report_mismatch("angle_valid", got.angle_valid, want.angle_valid);
                if (got.area !== want.area) report_mismatch("area", got.area, want.area);
            end
        end
    end

    initial begin
        geom_t g;
        pair_row_t r;
        int mode;
        i_rst_n = 1'b0;
        pt_if.valid = 1'b0;
        pt_if.ax = '0;
        pt_if.ay = '0;
        pt_if.bx = '0;
        pt_if.by = '0;

        // both points at origin
        g = '0;
        add_row(0, 0, 0, 0, 1, g);
        // right angle on the unit axes
        g = '0;
        g.dist_a = 256;
        g.dist_b = 256;
        g.dist_ab = 362;
        g.angle_deg = DEG90;
        g.angle_valid = 1'b1;
        g.area = 128;
        add_row(256, 0, 0, 256, 1, g);
        // same point twice
        g = '0;
        g.dist_a = 256;
        g.dist_b = 256;
        g.angle_valid = 1'b1;
        add_row(256, 0, 256, 0, 1, g);
        // opposite points
        g = '0;
        g.dist_a = 256;
        g.dist_b = 256;
        g.dist_ab = 512;
        g.angle_deg = DEG180;
        g.angle_valid = 1'b1;
        add_row(256, 0, -256, 0, 1, g);
        g = '0;
        add_row(0, 0, CMAX, CMIN, 0, g);
        add_row(CMIN, 5, 0, 0, 0, g);
        add_row(CMAX, CMAX, CMIN, CMIN, 0, g);
        add_row(CMIN, CMIN, CMIN, CMIN, 0, g);
        add_row(CMIN, CMIN, CMAX, CMAX, 0, g);
        add_row(CMAX, CMIN, CMIN, CMAX, 0, g);
        add_row(CMAX, 0, 0, CMIN, 0, g);
        add_row(-1, -1, 1, 1, 0, g);
        add_row(1, 0, 1, 1, 0, g);
        add_row(1000, 1, 1, 1000, 0, g);
        add_row(-3000, 7, 5, -2999, 0, g);
        add_row(1, 1, 1, 0, 0, g);
        add_row(CMAX, 1, CMAX, -1, 0, g);

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (pair_table[i]) send_pair(pair_table[i]);
        drain_results();

        for (int n = 0; n < RAND_PAIRS; n++) begin
            no_gaps = (n >= 250 && n < 350);
            mode = $urandom_range(0, 9);
            r.known = 0;
            r.want = '0;
            if (mode < 5) begin
                r.ax = rand_coord(0);
                r.ay = rand_coord(0);
                r.bx = rand_coord(0);
                r.by = rand_coord(0);
            end else begin
                r.ax = rand_coord($urandom_range(0, 4));
                r.ay = rand_coord($urandom_range(0, 4));
                r.bx = rand_coord($urandom_range(0, 4));
                r.by = rand_coord($urandom_range(0, 4));
            end
            send_pair(r);
        end
        no_gaps = 0;
        drain_results();
        repeat (LATENCY * 2) @(posedge i_clk);

        if (fail_cnt == 0 && pending_geom.size() == 0) begin
            $display("vector_pair_distance_angle_area_core verification clean");
        end else begin
            $display("vector_pair_distance_angle_area_core verification failed");
        end
        $finish;
    end
endmodule
